>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on aclk, masked while aresetn is low.
`define SST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication form of the same check.
`define SST_ASSERT_IMP(lbl, pre, post, msg) \
    `SST_ASSERT(lbl, (pre) |-> (post), msg)

`endif

>>> hw/rtl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    localparam int OP_W      = 3;
    localparam int NAME_W    = 64;
    localparam int SCOPE_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT        = 3'd0,
        OP_REMOVE        = 3'd1,
        OP_LOOKUP_SCOPED = 3'd2,
        OP_LOOKUP_NAME   = 3'd3,
        OP_CLEAR         = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Hit flags one cell reports to the select logic.
    typedef struct packed {
        logic name_hit;
        logic scoped_hit;
    } cell_hit_t;

endpackage

>>> hw/rtl/sst_cell.sv
`timescale 1ns / 1ps

// One table entry: stores a name/scope pair and registers its compare result.
module sst_cell
    import sst_pkg::*;
(
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [NAME_W-1:0]  wr_name,
    input  logic [SCOPE_W-1:0] wr_scope,
    input  logic               cmp_en,
    input  logic [NAME_W-1:0]  cmp_name,
    input  logic [SCOPE_W-1:0] cmp_scope,
    output cell_hit_t          hit
);

    logic [NAME_W-1:0]  name_reg;
    logic [SCOPE_W-1:0] scope_reg;
    cell_hit_t          hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            name_reg  <= wr_name;
            scope_reg <= wr_scope;
        end
        if (cmp_en) begin
            hit_reg.name_hit   <= (name_reg == cmp_name);
            hit_reg.scoped_hit <= (name_reg == cmp_name) && (scope_reg == cmp_scope);
        end
    end

    assign hit = hit_reg;

endmodule

>>> hw/rtl/sst_prio.sv
`timescale 1ns / 1ps

// Lowest-set-bit select: isolate the lowest hit, then encode its position.
module sst_prio #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]         vec,
    output logic                     any,
    output logic [$clog2(WIDTH)-1:0] idx
);

    localparam int IW = $clog2(WIDTH);

    logic [WIDTH-1:0] lowest;

    assign lowest = vec & (~vec + WIDTH'(1));
    assign any    = |vec;

    always_comb begin
        idx = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (lowest[i]) begin
                idx = idx | IW'(i);
            end
        end
    end

endmodule

>>> hw/rtl/scoped_symbol_table.sv
`timescale 1ns / 1ps

// Stack-ordered symbol table of 64-bit name keys with 8-bit scope numbers.
// Each operation has a compare step and a resolve step: on the accepting edge
// every entry cell compares its stored pair against the incoming key and scope
// and registers the hit; once the result register is free or draining, the
// select logic picks the newest scoped hit or the oldest name hit, updates the
// entry count, writes the cell on insert and loads the result register. The
// input side stays stalled from acceptance until that resolve, so a new
// transaction is taken only after the last one is resolved. Entries at or above
// the count are masked from every search, so no entry needs clearing after reset.
module scoped_symbol_table
    import sst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // op[2:0], name_key[66:3], scope[74:67], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], entry_index[8:3], entry_count[15:9]
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RES  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg;
    logic [NAME_W-1:0]  key_reg;
    logic [SCOPE_W-1:0] scope_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    logic [OP_W-1:0]    in_op;
    logic [NAME_W-1:0]  in_key;
    logic [SCOPE_W-1:0] in_scope;
    logic               accept;
    logic               fire;
    logic               do_insert;

    cell_hit_t          hits [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] live_mask;
    logic [TABLE_DEPTH-1:0] scoped_vec, scoped_rev, name_vec;

    logic               scoped_any, name_any;
    logic [IDX_W-1:0]   scoped_ridx, name_idx, scoped_idx;

    status_t            status_res;
    logic [IDX_W-1:0]   idx_res;

    // Unpack the slave transaction.
    assign in_op    = s_tdata[2:0];
    assign in_key   = s_tdata[66:3];
    assign in_scope = s_tdata[74:67];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Resolve only when the result register is free or draining this cycle.
    assign fire     = (state_reg == ST_RES) && (!m_tvalid_reg || m_tready);

    // Entry cells.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sst_cell u_cell (
            .aclk      (aclk),
            .wr_en     (do_insert && (count_reg[IDX_W-1:0] == IDX_W'(g))),
            .wr_name   (key_reg),
            .wr_scope  (scope_reg),
            .cmp_en    (accept),
            .cmp_name  (in_key),
            .cmp_scope (in_scope),
            .hit       (hits[g])
        );
    end

    // Mask off entries at or above the count and gather hit vectors.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            live_mask[i]                  = (CNT_W'(i) < count_reg);
            scoped_vec[i]                 = hits[i].scoped_hit && live_mask[i];
            name_vec[i]                   = hits[i].name_hit && live_mask[i];
            scoped_rev[TABLE_DEPTH-1-i]   = scoped_vec[i];
        end
    end

    // Newest-first scoped search runs on the reversed vector.
    sst_prio #(.WIDTH(TABLE_DEPTH)) u_prio_scoped (
        .vec (scoped_rev),
        .any (scoped_any),
        .idx (scoped_ridx)
    );

    sst_prio #(.WIDTH(TABLE_DEPTH)) u_prio_name (
        .vec (name_vec),
        .any (name_any),
        .idx (name_idx)
    );

    assign scoped_idx = LAST_IDX - scoped_ridx;

    // Decode the operation and compute the result and new count.
    always_comb begin
        status_res = ST_OK;
        idx_res    = '0;
        count_next = count_reg;
        do_insert  = 1'b0;
        unique case (op_reg)
            OP_INSERT: begin
                if (scoped_any) begin
                    status_res = ST_DUPLICATE;
                end else if (count_reg == DEPTH_CNT) begin
                    status_res = ST_FULL;
                end else begin
                    idx_res    = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    do_insert  = fire;
                end
            end
            OP_REMOVE: begin
                if (count_reg == '0) begin
                    status_res = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    idx_res    = count_next[IDX_W-1:0];
                end
            end
            OP_LOOKUP_SCOPED: begin
                if (scoped_any) begin
                    idx_res = scoped_idx;
                end else begin
                    status_res = ST_NOT_FOUND;
                end
            end
            OP_LOOKUP_NAME: begin
                if (name_any) begin
                    idx_res = name_idx;
                end else begin
                    status_res = ST_NOT_FOUND;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                // Unused codes leave the table alone.
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RES;
            ST_RES:  if (fire)   state_next = ST_IDLE;
            default:             state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the request for the resolve cycle, load the result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            scope_reg <= in_scope;
        end
        if (fire) begin
            m_tdata_reg <= {OUT_CNT_W'(count_next), OUT_IDX_W'(idx_res), status_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SST_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "entry count above table depth")
    `SST_ASSERT_IMP(a_idx_zero, m_tvalid_reg && (m_tdata_reg[2:0] != ST_OK),
        m_tdata_reg[8:3] == '0, "nonzero index with failing status")
    `SST_ASSERT_IMP(a_fire_idle, fire, ##1 s_tready, "input not reopened after resolve")
    `SST_ASSERT_IMP(a_insert_count, do_insert,
        ##1 (count_reg == $past(count_reg) + CNT_W'(1)), "insert did not bump count")

endmodule
